// ===== sv/text_console_cell_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text_console_cell_writer_assert.svh
// assertion macros shared by the console monitor
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, codes and types of the text console cell writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_CELLS  = 8;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CELL_W = 16;

  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [7:0] DEFAULT_ATTR_RST = 8'h0f;
  localparam logic [7:0] ERROR_ATTR_RST   = 8'hf4;
  localparam logic [7:0] CHAR_NEWLINE     = 8'd10;
  localparam logic [7:0] CHAR_TAB         = 8'd9;
  localparam logic [7:0] CHAR_ERROR       = 8'h45;
  localparam logic [7:0] CHAR_SPACE       = 8'h20;

  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ERROR_ATTR   = 1'b1;

  typedef enum logic [1:0] {
    CMD_PRINT = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] character;
    logic [7:0] attribute;
    logic [6:0] col;
    logic [4:0] row;
    logic       use_cursor;
  } req_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] read_char;
    logic [7:0] read_attr;
    logic       position_error;
  } rsp_t;

  typedef struct packed {
    logic [7:0] default_attr;
    logic [7:0] error_attr;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic sweep;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== sv/tcw_regs.sv =====
// ----------------------------------------------------------------------------
// tcw_regs
// apb configuration registers: default and error attributes
// ----------------------------------------------------------------------------
module tcw_regs
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [7:0]           default_attr;
  logic [7:0]           error_attr;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RST;
      error_attr   <= ERROR_ATTR_RST;
    end else if (wr) begin
      case (idx)
        REG_DEFAULT_ATTR: default_attr <= pwdata[7:0];
        REG_ERROR_ATTR:   error_attr   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEFAULT_ATTR: prdata = {24'h0, default_attr};
      REG_ERROR_ATTR:   prdata = {24'h0, error_attr};
      default:          prdata = 32'h0;
    endcase
  end

  assign cfg.default_attr = default_attr;
  assign cfg.error_attr   = error_attr;

endmodule

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer: clearing pass, command execution, memory sweeps, response
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      case (state)
        S_INIT: begin
          if (sts.sweep_done) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= sts.need_sweep ? S_SWEEP : S_DONE;
        end
        S_SWEEP: begin
          if (sts.sweep_done) state <= S_DONE;
        end
        S_DONE: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.exec   = (state == S_EXEC);
    cmd.sweep  = (state == S_INIT) || (state == S_SWEEP);
    cmd.finish = (state == S_DONE) && sts.out_free;
  end

endmodule

// ===== sv/tcw_dp.sv =====
// ----------------------------------------------------------------------------
// tcw_dp
// datapath: cell memory with rotating row base, cursor, sweep counter and
// response register
// ----------------------------------------------------------------------------
module tcw_dp
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  cfg_t       cfg,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp
);

  logic [CELL_W-1:0] cells [CELL_COUNT];

  req_t              item;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  top;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_last;
  logic [CELL_W-1:0] fill;
  logic [CELL_W-1:0] rdata;

  logic              is_print, is_clear, is_read, bad, err_print;
  logic              is_nl, is_tab, scroll, cell_we;
  logic [COL_W-1:0]  pos_col, wr_col, col_next;
  logic [ROW_W-1:0]  pos_row, wr_row, phys_row, top_next;
  logic [ROW_W:0]    phys_sum, adv_row, row_next;
  logic [COL_W:0]    inc_col, tab_col;
  logic [ADDR_W-1:0] cell_addr, blank_base, mem_waddr;
  logic [CELL_W-1:0] cell_data, mem_wdata;
  logic [7:0]        attr_eff;
  logic              mem_we;
  rsp_t              rsp_next;

  assign is_print  = (item.command == CMD_PRINT);
  assign is_clear  = (item.command == CMD_CLEAR);
  assign is_read   = (item.command == CMD_READ);
  assign bad       = (int'(item.col) >= COLUMNS) || (int'(item.row) >= ROWS);
  assign err_print = is_print && !item.use_cursor && bad;
  assign is_nl     = (item.character == CHAR_NEWLINE);
  assign is_tab    = (item.character == CHAR_TAB);

  assign pos_col = (is_print && item.use_cursor) ? cur_col : item.col[COL_W-1:0];
  assign pos_row = (is_print && item.use_cursor) ? cur_row : item.row[ROW_W-1:0];
  assign wr_col  = err_print ? COL_W'(COLUMNS - 1) : pos_col;
  assign wr_row  = err_print ? ROW_W'(ROWS - 1) : pos_row;

  // logical row to physical row through the rotating base
  assign phys_sum = {1'b0, wr_row} + {1'b0, top};
  assign phys_row = (phys_sum >= (ROW_W+1)'(ROWS)) ?
                    ROW_W'(phys_sum - (ROW_W+1)'(ROWS)) : phys_sum[ROW_W-1:0];
  assign cell_addr  = ADDR_W'(ADDR_W'(phys_row) * ADDR_W'(COLUMNS)) + ADDR_W'(wr_col);
  assign blank_base = ADDR_W'(ADDR_W'(top) * ADDR_W'(COLUMNS));
  assign top_next   = (top == ROW_W'(ROWS - 1)) ? '0 : top + ROW_W'(1);

  assign attr_eff  = (item.attribute == 8'h00) ? cfg.default_attr : item.attribute;
  assign cell_data = err_print ? {cfg.error_attr, CHAR_ERROR} : {attr_eff, item.character};
  assign cell_we   = is_print && (err_print || (!is_nl && !is_tab));

  // cursor advance
  assign inc_col = {1'b0, pos_col} + (COL_W+1)'(1);
  assign tab_col = (COL_W+1)'((int'(pos_col) / TAB_CELLS + 1) * TAB_CELLS);
  assign adv_row = {1'b0, pos_row} + (ROW_W+1)'(1);

  always_comb begin
    if (is_nl) begin
      col_next = '0;
      row_next = adv_row;
    end else if (is_tab) begin
      if (int'(tab_col) >= COLUMNS) begin
        col_next = '0;
        row_next = adv_row;
      end else begin
        col_next = tab_col[COL_W-1:0];
        row_next = {1'b0, pos_row};
      end
    end else begin
      if (int'(inc_col) >= COLUMNS) begin
        col_next = '0;
        row_next = adv_row;
      end else begin
        col_next = inc_col[COL_W-1:0];
        row_next = {1'b0, pos_row};
      end
    end
  end

  assign scroll = is_print && !err_print && (row_next == (ROW_W+1)'(ROWS));

  assign sts.need_sweep = is_clear || scroll;
  assign sts.sweep_done = (sweep_addr == sweep_last);
  assign sts.out_free   = !rsp_valid || rsp_ready;

  assign mem_we    = cmd.sweep || (cmd.exec && cell_we);
  assign mem_waddr = cmd.sweep ? sweep_addr : cell_addr;
  assign mem_wdata = cmd.sweep ? fill : cell_data;

  always_ff @(posedge clk) begin
    if (mem_we) cells[mem_waddr] <= mem_wdata;
    if (cmd.exec && is_read) rdata <= cells[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col    <= '0;
      cur_row    <= '0;
      top        <= '0;
      sweep_addr <= '0;
      sweep_last <= ADDR_W'(CELL_COUNT - 1);
      fill       <= '0;
    end else if (cmd.exec) begin
      if (is_clear) begin
        cur_col    <= '0;
        cur_row    <= '0;
        top        <= '0;
        sweep_addr <= '0;
        sweep_last <= ADDR_W'(CELL_COUNT - 1);
        fill       <= {cfg.default_attr, CHAR_SPACE};
      end else if (is_print && !err_print) begin
        cur_col <= col_next;
        cur_row <= scroll ? ROW_W'(ROWS - 1) : row_next[ROW_W-1:0];
        if (scroll) begin
          top        <= top_next;
          sweep_addr <= blank_base;
          sweep_last <= blank_base + ADDR_W'(COLUMNS - 1);
          fill       <= '0;
        end
      end
    end else if (cmd.sweep) begin
      sweep_addr <= sweep_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    rsp_next                = '0;
    rsp_next.cursor_col     = 7'(cur_col);
    rsp_next.cursor_row     = 5'(cur_row);
    rsp_next.position_error = err_print || (is_read && bad);
    if (is_read && !bad) begin
      rsp_next.read_char = rdata[7:0];
      rsp_next.read_attr = rdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) rsp <= rsp_next;
  end

endmodule

// ===== sv/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer
// 25x80 character/attribute screen with cursor, print, clear and cell read
// ----------------------------------------------------------------------------
// req channel (valid/ready) carries one command per transaction; rsp channel
// (valid/ready) returns one response per command with the cursor after the
// command, the cell read back and the position error flag.
// after rst the cell memory is swept to zero, one cell per cycle; req_ready
// stays low until the sweep is done. apb writes are taken during that time.
// print and read: a request is loaded in idle, executed, and its response is
// registered in the done state; the next request is taken back in idle.
// a print that moves the cursor past the last row scrolls by moving the row
// base and blanking one row. clear fills all 2000 cells. both run a memory
// sweep before the response.
// a stalled rsp holds in the response register; the next request is taken
// and executed meanwhile, and its response waits until the register frees.
// ----------------------------------------------------------------------------
module text_console_cell_writer
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tcw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== sv/tcw_monitor.sv =====
// ----------------------------------------------------------------------------
// tcw_monitor
// port-level assertions for the text console cell writer, bound to the top
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_assert.svh"

module tcw_monitor
  import tcw_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  logic cursor_ok;
  logic no_data;
  logic err_rsp;
  logic rsp_stall;

  assign cursor_ok = (int'(rsp.cursor_col) < COLUMNS) && (int'(rsp.cursor_row) < ROWS);
  assign no_data   = (rsp.read_char == 8'h00) && (rsp.read_attr == 8'h00);
  assign err_rsp   = rsp_valid && rsp.position_error;
  assign rsp_stall = rsp_valid && !rsp_ready;

  `TCW_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

  `TCW_ASSERT_IMP(a_cursor_range, rsp_valid, cursor_ok, "cursor off screen")

  `TCW_ASSERT_IMP(a_error_no_data, err_rsp, no_data, "cell data with position error")

  `TCW_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind text_console_cell_writer tcw_monitor u_monitor (.*);
